/* hw/rtl/tcw_pkg.sv */
// Shared constants, codes and the command word type for the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] CLS_PUT     = 3'd0;
  localparam logic [2:0] CLS_NEWLINE = 3'd1;
  localparam logic [2:0] CLS_CLEAR   = 3'd2;
  localparam logic [2:0] CLS_READ    = 3'd3;
  localparam logic [2:0] CLS_NOP     = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  ch;
    logic [10:0] idx;
  } cmd_t;

endpackage

/* hw/rtl/tcw_front.sv */
// Front end: accepts input words and classifies them into command words.
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_char_code,
  input  logic [10:0]      in_cell_index,
  input  logic             init_busy,
  input  logic             q_full,
  output logic             q_push,
  output tcw_pkg::cmd_t    q_cmd
);
  import tcw_pkg::*;

  localparam logic [15:0] CELLS_W = 16'(COLUMNS * ROWS);

  logic  vld_r, vld_nxt;
  cmd_t  cmd_r, cmd_nxt;
  logic  accept;

  assign busy   = init_busy || (vld_r && q_full);
  assign accept = start && !busy;
  assign q_push = vld_r && !q_full;
  assign q_cmd  = cmd_r;

  always_comb begin
    cmd_nxt     = cmd_r;
    vld_nxt     = vld_r;
    if (q_push) begin
      vld_nxt = 1'b0;
    end
    if (accept) begin
      vld_nxt     = 1'b1;
      cmd_nxt.ch  = in_char_code;
      cmd_nxt.idx = in_cell_index;
      unique case (in_op)
        OP_PUT: begin
          cmd_nxt.cls = (in_char_code == NEWLINE_CODE) ? CLS_NEWLINE : CLS_PUT;
        end
        OP_CLEAR: begin
          cmd_nxt.cls = CLS_CLEAR;
        end
        OP_READ: begin
          // out-of-range reads return zero, same as a no-op
          cmd_nxt.cls = (16'(in_cell_index) < CELLS_W) ? CLS_READ : CLS_NOP;
        end
        default: begin
          cmd_nxt.cls = CLS_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

/* hw/rtl/tcw_queue.sv */
// Short command queue between front end and back end.
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tcw_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);
  import tcw_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           entry_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/tcw_back.sv */
// Back end: screen memory, cursor, scroll and clear sequencer, result register.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    attr,
  input  tcw_pkg::cmd_t cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          init_busy,
  output logic          out_strobe,
  output logic [6:0]    out_cursor_col,
  output logic [4:0]    out_cursor_row,
  output logic [15:0]   out_cell_value
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LAST      = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] FILL_BASE = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [15:0]   RESET_BLANK = {RESET_ATTR, SPACE_CODE};

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_q;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] base_r, base_nxt;

  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic [AW-1:0] ra;
  logic          emit, emit_rd;
  logic          wrap;
  logic [15:0]   blank;

  logic          out_strobe_r;
  logic [6:0]    out_col_r;
  logic [4:0]    out_row_r;
  logic [15:0]   out_cell_r;

  assign blank     = {attr, SPACE_CODE};
  assign init_busy = (state_r == S_INIT);
  assign wrap      = (cmd.cls == CLS_NEWLINE) || (col_r == COL_LAST);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    wptr_nxt  = wptr_r;
    pend_nxt  = pend_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    we        = 1'b0;
    wa        = ptr_r;
    wd        = blank;
    ra        = ptr_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_rd   = 1'b0;
    unique case (state_r)
      S_INIT: begin
        we      = 1'b1;
        wd      = RESET_BLANK;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        pend_nxt = 1'b0;
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (cmd.cls)
            CLS_PUT, CLS_NEWLINE: begin
              if (cmd.cls == CLS_PUT) begin
                we = 1'b1;
                wa = base_r + AW'(col_r);
                wd = {attr, cmd.ch};
              end
              if (!wrap) begin
                col_nxt = col_r + 1'b1;
                emit    = 1'b1;
              end else begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  // cursor stays on the last row, screen moves up
                  ptr_nxt   = COLS_A;
                  state_nxt = S_SCROLL;
                end else begin
                  row_nxt  = row_r + 1'b1;
                  base_nxt = base_r + COLS_A;
                  emit     = 1'b1;
                end
              end
            end
            CLS_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              base_nxt  = '0;
              ptr_nxt   = '0;
              state_nxt = S_FILL;
            end
            CLS_READ: begin
              ra        = AW'(cmd.idx);
              state_nxt = S_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        emit      = 1'b1;
        emit_rd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        // read one cell ahead, write the previous one a row up
        ra       = ptr_r;
        we       = pend_r;
        wa       = wptr_r;
        wd       = rd_q;
        pend_nxt = 1'b1;
        wptr_nxt = ptr_r - COLS_A;
        ptr_nxt  = ptr_r + 1'b1;
        if (ptr_r == LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        we        = 1'b1;
        wa        = wptr_r;
        wd        = rd_q;
        pend_nxt  = 1'b0;
        ptr_nxt   = FILL_BASE;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        we      = 1'b1;
        wa      = ptr_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      base_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      pend_r       <= pend_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      base_r       <= base_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    wptr_r     <= wptr_nxt;
    out_col_r  <= 7'(col_nxt);
    out_row_r  <= 5'(row_nxt);
    out_cell_r <= emit_rd ? rd_q : 16'd0;
  end

  assign out_strobe     = out_strobe_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_value = out_cell_r;

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < COLUMNS)
    else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r < ROWS)
    else $error("cursor row out of range");
  a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == AW'(int'(row_r) * COLUMNS))
    else $error("row base address out of step with cursor row");
  a_drain_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> pend_r)
    else $error("scroll drain without a pending copy");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("command popped while sequencer busy");
`endif

endmodule

/* hw/rtl/text_console_writer_unit.sv */
// Top level of the text console writer: front end, command queue, back end, attribute register.
//
// Text console writer. A command word is taken at a clock edge with start high and busy
// low; each command produces exactly one result, shown for one cycle with out_strobe high,
// carrying the cursor after the command. Results cannot be held off, so the block never
// waits on the receiver. Commands flow through a one-word front register and a two-word
// queue into a sequencer that owns the single-port-write, single-port-read screen memory;
// throughput is set by that sequencer: it handles a put, newline or no-op in its idle state,
// a read with an added read state, a clear by blanking every cell and a scroll by copying
// every row but the first one row up, then blanking the last row. After reset the sequencer
// first walks the memory writing blank cells with attribute 0x0F; busy stays high meanwhile.
// The attribute register (cfg_data) is always ready and should be written only while no
// command is in flight.
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_strobe,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [15:0] out_cell_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tcw_pkg::*;

  logic [7:0] attr_r, attr_nxt;
  logic       init_busy;
  logic       q_full, q_empty, q_push, q_pop;
  cmd_t       push_cmd, head_cmd;

  assign cfg_ready = 1'b1;
  assign attr_nxt  = (cfg_valid && cfg_ready) ? cfg_data : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .init_busy     (init_busy),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .attr           (attr_r),
    .cmd            (head_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .out_strobe     (out_strobe),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_value (out_cell_value)
  );

endmodule
